// ===== sv/rwfm_pkg.sv =====
// Shared types, limit tables and conversion helpers for the rail window fault monitor.
package rwfm_pkg;

  localparam int RAIL_COUNT_DEF = 18;
  localparam int RAIL_W         = 5;
  localparam int SAMPLE_W       = 16;
  localparam int MASK_W         = 18;
  localparam int CNT_W          = 2;
  localparam int CONV_W         = 12;
  localparam int APB_AW         = 2;
  localparam int APB_DW         = 32;

  localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(63);
  localparam logic [APB_AW-1:0] ADDR_ENABLE_MASK = APB_AW'(0);

  localparam logic [RAIL_W-1:0] TEMP_FIRST = RAIL_W'(2);
  localparam logic [RAIL_W-1:0] TEMP_LAST  = RAIL_W'(5);

  localparam logic [CNT_W-1:0] CNT_NONE  = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic                fault;
    logic [SAMPLE_W-1:0] cap_one;
    logic [SAMPLE_W-1:0] cap_two;
    logic [SAMPLE_W-1:0] cap_three;
  } strike_t;

  function automatic logic [SAMPLE_W-1:0] upper_limit(input logic [RAIL_W-1:0] rail);
    logic [SAMPLE_W-1:0] v;
    case (rail)
      5'd0:  v = 16'd906;
      5'd1:  v = 16'd1557;
      5'd2,
      5'd3,
      5'd4,
      5'd5:  v = 16'd800;
      5'd6,
      5'd7:  v = 16'd10000;
      5'd8:  v = 16'd3414;
      5'd9:  v = 16'd1596;
      5'd10: v = 16'd4095;
      5'd11: v = 16'd4286;
      5'd12: v = 16'd10000;
      5'd13,
      5'd14: v = 16'd4095;
      5'd15: v = 16'd3686;
      5'd16: v = 16'd3494;
      5'd17: v = 16'd2720;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] lower_limit(input logic [RAIL_W-1:0] rail);
    logic [SAMPLE_W-1:0] v;
    case (rail)
      5'd0:  v = 16'd596;
      5'd1:  v = 16'd1464;
      5'd2,
      5'd3,
      5'd4,
      5'd5:  v = 16'd7872;
      5'd8:  v = 16'd2792;
      5'd9:  v = 16'd1306;
      5'd10: v = 16'd3350;
      5'd11: v = 16'd3507;
      5'd13,
      5'd14: v = 16'd3350;
      5'd15: v = 16'd3015;
      5'd16: v = 16'd2859;
      5'd17: v = 16'd2023;
      default: v = '0;
    endcase
    return v;
  endfunction

  // floor(upper / 10), the top of the near-zero window
  function automatic logic [SAMPLE_W-1:0] near_zero_limit(input logic [RAIL_W-1:0] rail);
    logic [SAMPLE_W-1:0] v;
    case (rail)
      5'd0:  v = 16'd90;
      5'd1:  v = 16'd155;
      5'd2,
      5'd3,
      5'd4,
      5'd5:  v = 16'd80;
      5'd6,
      5'd7:  v = 16'd1000;
      5'd8:  v = 16'd341;
      5'd9:  v = 16'd159;
      5'd10: v = 16'd409;
      5'd11: v = 16'd428;
      5'd12: v = 16'd1000;
      5'd13,
      5'd14: v = 16'd409;
      5'd15: v = 16'd368;
      5'd16: v = 16'd349;
      5'd17: v = 16'd272;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Sensor word to degrees/16: fold 13-bit two's complement, divide by 16 toward zero.
  function automatic logic signed [CONV_W-1:0] temp_conv(input logic [SAMPLE_W-1:0] w);
    logic signed [SAMPLE_W:0] v;
    logic signed [SAMPLE_W:0] r;
    v = signed'({w[SAMPLE_W-1], w});
    if (v >= 17'sd4096) begin
      v = v - 17'sd8192;
    end
    if (v < 17'sd0) begin
      r = (v + 17'sd15) >>> 4;
    end else begin
      r = v >>> 4;
    end
    return CONV_W'(r);
  endfunction

endpackage

// ===== sv/rwfm_window.sv =====
// Window check of one sample against its rail's active limits.
module rwfm_window
  import rwfm_pkg::*;
(
  input  logic [RAIL_W-1:0]   rail,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                full_check,
  output logic                ok
);

  logic [SAMPLE_W-1:0]      hi;
  logic [SAMPLE_W-1:0]      lo;
  logic                     is_temp;
  logic signed [CONV_W-1:0] s_c;
  logic signed [CONV_W-1:0] hi_c;
  logic signed [CONV_W-1:0] lo_c;

  always_comb begin
    hi      = full_check ? upper_limit(rail) : near_zero_limit(rail);
    lo      = full_check ? lower_limit(rail) : '0;
    is_temp = (rail >= TEMP_FIRST) && (rail <= TEMP_LAST);
    s_c     = temp_conv(sample);
    hi_c    = temp_conv(hi);
    lo_c    = temp_conv(lo);
    if (is_temp) begin
      ok = (s_c <= hi_c) && (s_c >= lo_c);
    end else begin
      ok = (sample <= hi) && (sample >= lo);
    end
  end

endmodule

// ===== sv/rwfm_rail_state.sv =====
// Per-rail strike counters and sample captures with read-modify-write update.
module rwfm_rail_state
  import rwfm_pkg::*;
#(
  parameter int RAIL_COUNT = RAIL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic                in_range,
  input  logic [RAIL_W-1:0]   rail,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                ok,
  output strike_t             res
);

  localparam int IDX_W = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;

  logic [CNT_W-1:0]    counts    [RAIL_COUNT];
  logic [SAMPLE_W-1:0] cap_one   [RAIL_COUNT];
  logic [SAMPLE_W-1:0] cap_two   [RAIL_COUNT];
  logic [SAMPLE_W-1:0] cap_three [RAIL_COUNT];

  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    cnt;
  logic                strike;

  // Captures carry no reset: an entry is only ever read once its count covers it.
  always_comb begin
    idx           = in_range ? rail[IDX_W-1:0] : '0;
    cnt           = counts[idx];
    strike        = !ok && (cnt != CNT_THREE);
    res.count     = cnt;
    res.fault     = 1'b0;
    res.cap_one   = (cnt >= CNT_ONE)   ? cap_one[idx]   : '0;
    res.cap_two   = (cnt >= CNT_TWO)   ? cap_two[idx]   : '0;
    res.cap_three = (cnt == CNT_THREE) ? cap_three[idx] : '0;
    if (strike) begin
      res.count = cnt + CNT_ONE;
      case (cnt)
        CNT_NONE: res.cap_one   = sample;
        CNT_ONE:  res.cap_two   = sample;
        default: begin
          res.cap_three = sample;
          res.fault     = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RAIL_COUNT; i++) begin
        counts[i] <= CNT_NONE;
      end
    end else if (wr_en && in_range && strike) begin
      counts[idx] <= res.count;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_range && strike) begin
      case (cnt)
        CNT_NONE: cap_one[idx]   <= sample;
        CNT_ONE:  cap_two[idx]   <= sample;
        default:  cap_three[idx] <= sample;
      endcase
    end
  end

endmodule

// ===== sv/rail_window_fault_monitor.sv =====
// Top level of the rail window fault monitor: handshake, register port, result stage.
//
// Each input word names a rail and carries one 16-bit sample. The sample is
// checked against the rail's window (full limits when its enable_mask bit is
// set, 0..upper/10 otherwise; rails 2-5 compare converted temperatures).
// A failing sample under three strikes adds one and is captured; the third
// raises fault with all three captures. One result word leaves for every input word.
//
// Channels: in_valid/in_stall and out_valid/out_stall; a word moves on a
// rising edge with valid high and stall low.
// Path: an accepted input word waits in the input register and moves to the
// result register when that is free. Throughput: one word per cycle while
// out_stall is low, set by the read-modify-write of the rail's strike entry
// between the input register and the result register.
// Stall: when out_stall holds a result, the input register takes one more
// word and then in_stall rises; nothing is lost or repeated.
// Reset (rst, synchronous): all strike counts clear, enable_mask returns to
// 63, both registers empty. Configuration: APB, enable_mask at address 0.
module rail_window_fault_monitor
  import rwfm_pkg::*;
#(
  parameter int RAIL_COUNT = RAIL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // APB register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [RAIL_W-1:0]   rail_index,
  input  logic [SAMPLE_W-1:0] sample,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                in_bounds,
  output logic [CNT_W-1:0]    strike_count,
  output logic                fault,
  output logic [SAMPLE_W-1:0] first_capture,
  output logic [SAMPLE_W-1:0] second_capture,
  output logic [SAMPLE_W-1:0] third_capture
);

  logic [MASK_W-1:0]   enable_mask;
  logic [31:0]         mask_ext;

  // input register
  logic                held_valid;
  logic [RAIL_W-1:0]   held_rail;
  logic [SAMPLE_W-1:0] held_sample;

  logic                advance;
  logic                load;
  logic                take;
  logic                in_range;
  logic                full_check;
  logic                ok;
  strike_t             st;

  // ---- register port ----
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ENABLE_MASK) begin
      prdata = APB_DW'(enable_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= MASK_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ENABLE_MASK) begin
      enable_mask <= pwdata[MASK_W-1:0];
    end
  end

  // ---- handshake ----
  // Result register frees up when empty or being taken this cycle.
  assign advance  = !out_valid || !out_stall;
  assign load     = held_valid && advance;
  assign in_stall = held_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (load) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_rail   <= rail_index;
      held_sample <= sample;
    end
  end

  // ---- check and update ----
  // Rails past bit 17 have no enable bit and always get the near-zero check.
  assign mask_ext   = 32'(enable_mask);
  assign full_check = mask_ext[held_rail];
  assign in_range   = {1'b0, held_rail} < (RAIL_W + 1)'(RAIL_COUNT);

  rwfm_window u_window (
    .rail       (held_rail),
    .sample     (held_sample),
    .full_check (full_check),
    .ok         (ok)
  );

  rwfm_rail_state #(
    .RAIL_COUNT (RAIL_COUNT)
  ) u_rail_state (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (load),
    .in_range (in_range),
    .rail     (held_rail),
    .sample   (held_sample),
    .ok       (ok),
    .res      (st)
  );

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid;
    end
  end

  // Unknown rails report a clean, empty result and touch no state.
  always_ff @(posedge clk) begin
    if (load) begin
      if (in_range) begin
        in_bounds      <= ok;
        strike_count   <= st.count;
        fault          <= st.fault;
        first_capture  <= st.cap_one;
        second_capture <= st.cap_two;
        third_capture  <= st.cap_three;
      end else begin
        in_bounds      <= 1'b1;
        strike_count   <= CNT_NONE;
        fault          <= 1'b0;
        first_capture  <= '0;
        second_capture <= '0;
        third_capture  <= '0;
      end
    end
  end

endmodule
